/* hdl/stdf_pkg.sv */
// Shared constants, codes and byte functions for the scrolling text display feeder.
package stdf_pkg;

  localparam int TEXT_BYTES = 256;
  localparam int DIGITS     = 12;

  localparam int ADDR_W     = $clog2(TEXT_BYTES);
  localparam int WIN_MAX    = TEXT_BYTES - DIGITS;
  localparam int ELEM_W     = $clog2(DIGITS + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]  CMD_DCRAM_WR = 8'h10;
  localparam logic [15:0] INTERVAL_RST = 16'd1000;
  localparam logic [3:0]  DIR_FWD      = 4'd1;
  localparam logic [3:0]  DIR_BWD      = 4'd2;
  localparam int          MODE_WRAP    = 4;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_REDRAW = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET   = 2'd0,
    CFG_SPAN     = 2'd1,
    CFG_MODE     = 2'd2,
    CFG_INTERVAL = 2'd3
  } cfg_idx_e;

  function automatic logic [7:0] bit_rev(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

  // Map ASCII to the controller's character set.
  function automatic logic [7:0] char_code(input logic [7:0] c);
    logic [7:0] r;
    if (c >= 8'd64 && c <= 8'd95) begin
      r = c - 8'd48;
    end else if (c >= 8'd32 && c <= 8'd63) begin
      r = c + 8'd16;
    end else if (c >= 8'd97 && c <= 8'd122) begin
      r = c - 8'd80;
    end else begin
      r = 8'd79;
    end
    return r;
  endfunction

endpackage

/* hdl/stdf_cfg_if.sv */
// Configuration write channel.
interface stdf_cfg_if import stdf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/stdf_in_if.sv */
// Input request channel: tick, buffer write or redraw.
interface stdf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] write_address;
  logic [7:0] write_data;

  modport source (output valid, output operation, output write_address, output write_data,
                  input ready);
  modport sink   (input valid, input operation, input write_address, input write_data,
                  output ready);
endinterface

/* hdl/stdf_out_if.sv */
// Output channel carrying frame bytes to the display link.
interface stdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

/* hdl/scrolling_text_display_feeder.sv */
// Scrolling text display feeder top level: text store, scroll control, frame output.
// A write first reads the stored byte and checks it in S_WCHK, then sets up the window in
// S_START; a redraw or scroll step goes straight to setup. The frame then streams 13 bytes,
// one per cycle while the output staging has room (one text store read each). Ticks without a
// step and writes equal to the stored byte produce no frame. Reset is asynchronous, active
// low: text store reads as zero through per-entry valid bits, control registers take their defaults.
module scrolling_text_display_feeder import stdf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  stdf_cfg_if.sink    cfg_i,
  stdf_in_if.sink     in_i,
  stdf_out_if.source  out_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WCHK  = 4'b0010,
    S_START = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic [7:0]  off_q, span_q, mode_q;
  logic [15:0] ival_q;

  // Scroll state
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [15:0]       et_q, et_d;

  // Write and frame bookkeeping
  logic [ADDR_W-1:0] wa_q;
  logic [7:0]        wd_q;
  logic [ADDR_W-1:0] start_q, start_d;
  logic [ELEM_W-1:0] elem_q, elem_d;

  // Text store
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic [TEXT_BYTES-1:0] vld_q;
  logic              rd_vld_q;
  logic [7:0]        old_byte;

  // Read pipeline and output staging
  logic       pend_q, pend_d, pend_cmd_q, pend_cmd_d, pend_last_q, pend_last_d;
  logic       out_vld_q, skid_vld_q;
  logic [7:0] out_byte_q, skid_byte_q;
  logic       out_last_q, skid_last_q;
  logic       out_free, can_issue, issue;
  logic [7:0] arr_byte;

  // Tick arithmetic
  logic [ADDR_W-1:0] span_sat, off_sat, step_pos, start_calc;
  logic [ADDR_W:0]   pos_p1, fwd_lim, win_sum;
  logic [15:0]       et_inc;
  logic              step_hit;

  logic accept;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign accept      = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= '0;
      span_q <= '0;
      mode_q <= '0;
      ival_q <= INTERVAL_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_OFFSET:   off_q  <= cfg_i.data[7:0];
        CFG_SPAN:     span_q <= cfg_i.data[7:0];
        CFG_MODE:     mode_q <= cfg_i.data[7:0];
        CFG_INTERVAL: ival_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Scroll step arithmetic
  assign span_sat = (int'(span_q) > WIN_MAX) ? ADDR_W'(WIN_MAX) : span_q[ADDR_W-1:0];
  assign off_sat  = (int'(off_q) > WIN_MAX) ? ADDR_W'(WIN_MAX) : off_q[ADDR_W-1:0];
  assign et_inc   = (et_q != 16'hFFFF) ? et_q + 16'd1 : et_q;
  assign step_hit = (et_inc >= ival_q) && (ival_q != '0) && (span_sat != '0);
  assign pos_p1   = {1'b0, pos_q} + (ADDR_W+1)'(1);
  assign fwd_lim  = (int'(pos_p1) > WIN_MAX) ? (ADDR_W+1)'(WIN_MAX) : pos_p1;

  always_comb begin
    step_pos = pos_q;
    if (mode_q[3:0] == DIR_FWD) begin
      if (fwd_lim > {1'b0, span_sat}) begin
        step_pos = mode_q[MODE_WRAP] ? '0 : span_sat;
      end else begin
        step_pos = fwd_lim[ADDR_W-1:0];
      end
    end else if (mode_q[3:0] == DIR_BWD) begin
      if (pos_q != '0) begin
        step_pos = pos_q - ADDR_W'(1);
      end else if (mode_q[MODE_WRAP]) begin
        step_pos = span_sat - ADDR_W'(1);
      end
    end
  end

  // Window start, saturated so the window stays inside the buffer
  assign win_sum    = {1'b0, off_sat} + {1'b0, pos_q};
  assign start_calc = (int'(win_sum) > WIN_MAX) ? ADDR_W'(WIN_MAX) : win_sum[ADDR_W-1:0];

  // Text store and its valid bits
  assign old_byte = rd_vld_q ? ram_rdata : 8'd0;
  assign ram_we   = (state_q == S_WCHK) && (old_byte != wd_q);

  always_comb begin
    if (state_q == S_EMIT) begin
      ram_raddr = ADDR_W'(int'(start_q) + DIGITS - int'(elem_q));
    end else begin
      ram_raddr = in_i.write_address[ADDR_W-1:0];
    end
  end

  stdf_ram #(
    .WIDTH(8),
    .DEPTH(TEXT_BYTES)
  ) u_text_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wa_q),
    .wdata_i(wd_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[ram_raddr];
      if (ram_we) begin
        vld_q[wa_q] <= 1'b1;
      end
    end
  end

  // Issue one frame element a cycle while the staging has room
  assign out_free  = !out_vld_q || out_o.ready;
  assign can_issue = !skid_vld_q && !(pend_q && out_vld_q && !out_o.ready);
  assign issue     = (state_q == S_EMIT) && can_issue;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    et_d        = et_q;
    start_d     = start_q;
    elem_d      = elem_q;
    pend_d      = 1'b0;
    pend_cmd_d  = 1'b0;
    pend_last_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_i.operation)
            OP_TICK: begin
              if (step_hit) begin
                et_d    = '0;
                pos_d   = step_pos;
                state_d = S_START;
              end else begin
                et_d = et_inc;
                if (ival_q == '0 || mode_q == '0) begin
                  pos_d = '0;
                end
              end
            end
            OP_WRITE: begin
              if ({1'b0, in_i.write_address} < 9'(TEXT_BYTES)) begin
                state_d = S_WCHK;
              end
            end
            OP_REDRAW: state_d = S_START;
            default: ;
          endcase
        end
      end
      S_WCHK: begin
        state_d = (old_byte != wd_q) ? S_START : S_IDLE;
      end
      S_START: begin
        start_d = start_calc;
        elem_d  = '0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (issue) begin
          pend_d      = 1'b1;
          pend_cmd_d  = (elem_q == '0);
          pend_last_d = (int'(elem_q) == DIGITS);
          elem_d      = elem_q + ELEM_W'(1);
          if (int'(elem_q) == DIGITS) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      et_q        <= '0;
      elem_q      <= '0;
      pend_q      <= 1'b0;
      pend_cmd_q  <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      et_q        <= et_d;
      elem_q      <= elem_d;
      pend_q      <= pend_d;
      pend_cmd_q  <= pend_cmd_d;
      pend_last_q <= pend_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    if (accept) begin
      wa_q <= in_i.write_address[ADDR_W-1:0];
      wd_q <= in_i.write_data;
    end
  end

  // Byte arriving from the store this cycle
  assign arr_byte = pend_cmd_q ? bit_rev(CMD_DCRAM_WR) : bit_rev(char_code(old_byte));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= pend_q;
      end else begin
        out_vld_q  <= pend_q;
      end
    end else if (pend_q) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_vld_q) begin
        out_byte_q  <= skid_byte_q;
        out_last_q  <= skid_last_q;
        skid_byte_q <= arr_byte;
        skid_last_q <= pend_last_q;
      end else begin
        out_byte_q  <= arr_byte;
        out_last_q  <= pend_last_q;
      end
    end else if (pend_q) begin
      skid_byte_q <= arr_byte;
      skid_last_q <= pend_last_q;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.frame_byte = out_byte_q;
  assign out_o.frame_last = out_last_q;

endmodule

/* hdl/stdf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module stdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
